// ===== hdl/lab_pkg.sv =====
// ----------------------------------------------------------------------------
// lab_pkg - logo alpha blend / unblend shared definitions
// Opacity scale, divide-by-constant reciprocal and field widths.
// ----------------------------------------------------------------------------
package lab_pkg;

  // Full-scale opacity
  localparam int unsigned OPACITY_SCALE = 1000;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COLOR_W  = 21;
  localparam int unsigned DEPTH_W  = 10;
  localparam int unsigned RECIP_W  = 32;
  localparam int unsigned BD_W     = 5;
  localparam int unsigned SRC_W    = 28;                      // sample << up to 12
  localparam int unsigned DEN_W    = $clog2(OPACITY_SCALE + 1);
  localparam int unsigned WSRC_W   = DEN_W + 2;               // signed scale - depth

  // Exact add-mode divide: q0 = (mag * RECIP_CONST) >> RECIP_SHIFT is q or q-1
  localparam int unsigned RECIP_SHIFT = 32 + $clog2(OPACITY_SCALE);
  localparam logic [32:0] RECIP_CONST =
      33'((64'd1 << RECIP_SHIFT) / 64'(OPACITY_SCALE));

  localparam logic [DEN_W-1:0] SCALE_DEN  = DEN_W'(OPACITY_SCALE);
  localparam logic [DEN_W-1:0] SCALE_HALF = DEN_W'(OPACITY_SCALE / 2);
  localparam logic [DEPTH_W-1:0] ALPHA_MAX =
      (OPACITY_SCALE - 1 > 1023) ? DEPTH_W'(1023) : DEPTH_W'(OPACITY_SCALE - 1);

  localparam logic [BD_W-1:0] BD_MIN   = BD_W'(8);
  localparam logic [BD_W-1:0] BD_MAX   = BD_W'(16);
  localparam logic [BD_W-1:0] BD_RESET = BD_W'(8);

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_ERASE = 1'b1
  } cmd_e;

endpackage

// ===== hdl/logo_alpha_blend_and_unblend.sv =====
// ----------------------------------------------------------------------------
// logo_alpha_blend_and_unblend
// Six-stage pipeline that blends a logo into a pixel or removes it again.
// ----------------------------------------------------------------------------
// One pixel per clock is accepted unless the output stalls, and one result
// per pixel is returned. The pipeline is: weight multiplies, numerator sum
// and magnitude, reciprocal multiply (a fixed reciprocal of the opacity
// scale in add mode, the supplied reciprocal in erase mode), the quotient
// check product, quotient correction and sign, then the shift, rounding
// and saturation to the pixel range. All stages move together; when the
// result is not taken, the whole pipeline holds. Write sample bit depth via
// cfg only while no pixel is in flight; the block does not enforce this.
module logo_alpha_blend_and_unblend
  import lab_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [BD_W-1:0]            cfg_bit_depth_i,

  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [SAMPLE_W-1:0]        sample_i,
  input  logic signed [COLOR_W-1:0]  color_i,
  input  logic [DEPTH_W-1:0]         depth_i,
  input  logic [RECIP_W-1:0]         reciprocal_i,

  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [SAMPLE_W-1:0]        pixel_out_o
);

  logic adv;

  // ---------------------------------------------------------------- config
  logic [BD_W-1:0] bit_depth_q;
  logic [BD_W-1:0] bd_even;
  logic [BD_W-1:0] bd_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_depth_q <= BD_RESET;
    end else if (cfg_valid_i) begin
      bit_depth_q <= cfg_bit_depth_i;
    end
  end

  always_comb begin
    bd_even = bit_depth_q & ~BD_W'(1);
    if (bd_even < BD_MIN) begin
      bd_eff = BD_MIN;
    end else if (bd_even > BD_MAX) begin
      bd_eff = BD_MAX;
    end else begin
      bd_eff = bd_even;
    end
  end

  // ---------------------------------------------------------------- valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  assign adv         = !v6_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Weight products. add: src*(S-dep) + col*dep; erase: src*S - col*alpha
  logic                       is_add;
  logic [SRC_W-1:0]           src;
  logic [DEPTH_W-1:0]         alpha;
  logic [DEN_W-1:0]           den;
  logic signed [WSRC_W-1:0]   wsrc;
  logic [DEPTH_W-1:0]         wcol;
  logic signed [SRC_W+WSRC_W:0] pa_full;
  logic signed [COLOR_W+DEPTH_W:0] pb_full;

  logic                       cmd1_q;
  logic [31:0]                pa1_q;
  logic [31:0]                pb1_q;
  logic [DEN_W-1:0]           den1_q;
  logic [RECIP_W-1:0]         rec1_q;

  always_comb begin
    is_add = (cmd_e'(command_i) == CMD_ADD);
    src    = SRC_W'(sample_i) << (BD_W'(20) - bd_eff);
    alpha  = (depth_i < ALPHA_MAX) ? depth_i : ALPHA_MAX;
    den    = SCALE_DEN - DEN_W'(alpha);
    if (is_add) begin
      wsrc = $signed(WSRC_W'(SCALE_DEN)) - $signed(WSRC_W'(depth_i));
      wcol = depth_i;
    end else begin
      wsrc = $signed(WSRC_W'(SCALE_DEN));
      wcol = alpha;
    end
    pa_full = $signed({1'b0, src}) * wsrc;
    pb_full = color_i * $signed({1'b0, wcol});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q <= command_i;
      pa1_q  <= pa_full[31:0];
      pb1_q  <= 32'(pb_full);
      den1_q <= den;
      rec1_q <= reciprocal_i;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Numerator with wrap, then sign and magnitude
  logic [31:0]        n2;
  logic [DEN_W-1:0]   bias2;

  logic               cmd2_q;
  logic               neg2_q;
  logic [31:0]        mag2_q;
  logic [DEN_W-1:0]   den2_q;
  logic [RECIP_W-1:0] rec2_q;

  always_comb begin
    if (cmd_e'(cmd1_q) == CMD_ADD) begin
      bias2 = SCALE_HALF;
      n2    = pa1_q + pb1_q + 32'(bias2);
    end else begin
      bias2 = den1_q >> 1;
      n2    = pa1_q - pb1_q + 32'(bias2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd2_q <= cmd1_q;
      neg2_q <= n2[31];
      mag2_q <= n2[31] ? (32'd0 - n2) : n2;
      den2_q <= den1_q;
      rec2_q <= rec1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Reciprocal multiply-high: estimate of mag / divisor
  logic [32:0] mult3;
  logic [64:0] prod3;
  logic [31:0] q3;

  logic               cmd3_q;
  logic               neg3_q;
  logic [31:0]        mag3_q;
  logic [DEN_W-1:0]   den3_q;
  logic [31:0]        q3_q;

  always_comb begin
    mult3 = (cmd_e'(cmd2_q) == CMD_ADD) ? RECIP_CONST : 33'(rec2_q);
    prod3 = 65'(mag2_q) * 65'(mult3);
    if (cmd_e'(cmd2_q) == CMD_ADD) begin
      q3 = 32'(prod3 >> RECIP_SHIFT);
    end else begin
      q3 = prod3[63:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd3_q <= cmd2_q;
      neg3_q <= neg2_q;
      mag3_q <= mag2_q;
      den3_q <= den2_q;
      q3_q   <= q3;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Check product (q+1)*divisor, low 32 bits
  logic [31:0]        nq4;
  logic [DEN_W-1:0]   div4;
  logic [31+DEN_W:0]  t_full;

  logic        neg4_q;
  logic [31:0] mag4_q;
  logic [31:0] q4_q;
  logic [31:0] t4_q;

  always_comb begin
    nq4    = q3_q + 32'd1;
    div4   = (cmd_e'(cmd3_q) == CMD_ADD) ? SCALE_DEN : den3_q;
    t_full = (32 + DEN_W)'(nq4) * (32 + DEN_W)'(div4);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg4_q <= neg3_q;
      mag4_q <= mag3_q;
      q4_q   <= q3_q;
      t4_q   <= t_full[31:0];
    end
  end

  // ---------------------------------------------------------------- stage 5
  // One-step quotient correction, sign restored
  logic [31:0] q5;
  logic [31:0] res5_q;

  assign q5 = (t4_q <= mag4_q) ? (q4_q + 32'd1) : q4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res5_q <= neg4_q ? (32'd0 - q5) : q5;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Clamp at zero, scale back with rounding, saturate to pixel max
  logic [31:0]         v6;
  logic [31:0]         r6;
  logic [SAMPLE_W:0]   pmax6;
  logic [SAMPLE_W-1:0] pix6;
  logic [SAMPLE_W-1:0] pixel_out_q;

  always_comb begin
    pmax6 = (17'd1 << bd_eff) - 17'd1;
    v6    = res5_q[31] ? 32'd0 : (res5_q >> (BD_W'(18) - bd_eff));
    r6    = (v6 + 32'd1) >> 2;
    pix6  = (r6 < 32'(pmax6)) ? r6[SAMPLE_W-1:0] : pmax6[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pixel_out_q <= pix6;
    end
  end

  assign pixel_out_o = pixel_out_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - logo alpha blend / unblend
// Streams pixels through the block in add and erase mode across a range of
// bit-depth settings, with random idle and stall bursts on both sides. Each
// output pixel is checked in order against an in-bench blend predictor.
// ----------------------------------------------------------------------------
module testbench;
  import lab_pkg::*;

  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned DRAIN_CYCLES     = 12;
  localparam int unsigned RAND_PER_SETTING = 58;
  localparam int unsigned PLAN_LEN         = 9;
  // odd, below-range and above-range codes are part of the sweep
  localparam logic [BD_W-1:0] BD_PLAN [PLAN_LEN] = '{
    BD_W'(16), BD_W'(10), BD_W'(12), BD_W'(14), BD_W'(9),
    BD_W'(0), BD_W'(31), BD_W'(17), BD_W'(8)
  };

  typedef struct {
    cmd_e                       command;
    logic [SAMPLE_W-1:0]        sample;
    logic signed [COLOR_W-1:0]  color;
    logic [DEPTH_W-1:0]         depth;
    logic [RECIP_W-1:0]         reciprocal;
  } pix_item_t;

  typedef struct {
    pix_item_t           px;
    logic [SAMPLE_W-1:0] pixel;
  } pix_expect_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_valid_i     = 1'b0;
  logic                      cfg_ready_o;
  logic [BD_W-1:0]           cfg_bit_depth_i = BD_RESET;
  logic                      in_valid_i      = 1'b0;
  logic                      in_ready_o;
  logic                      command_i       = 1'b0;
  logic [SAMPLE_W-1:0]       sample_i        = '0;
  logic signed [COLOR_W-1:0] color_i         = '0;
  logic [DEPTH_W-1:0]        depth_i         = '0;
  logic [RECIP_W-1:0]        reciprocal_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i     = 1'b0;
  logic [SAMPLE_W-1:0]       pixel_out_o;

  pix_item_t   pixel_todo_q[$];
  pix_expect_t pixel_expect_q[$];
  pix_item_t   on_bus;
  logic [BD_W-1:0] bit_depth_model = BD_RESET;

  int unsigned pixels_queued  = 0;
  int unsigned pixels_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned erase_sent     = 0;
  int unsigned errors         = 0;
  int unsigned send_gap       = 0;
  int unsigned sink_stall     = 0;
  int unsigned gap_pct        = 20;
  int unsigned stall_pct      = 20;
  int unsigned quiet_cycles   = 0;

  logo_alpha_blend_and_unblend i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_bit_depth_i (cfg_bit_depth_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .sample_i        (sample_i),
    .color_i         (color_i),
    .depth_i         (depth_i),
    .reciprocal_i    (reciprocal_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_out_o     (pixel_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Odd codes round down, then clamp into 8..16
  function automatic logic [4:0] eff_depth(logic [BD_W-1:0] bd_reg);
    logic [4:0] bd;
    bd = bd_reg & 5'h1E;
    if (bd < BD_MIN) bd = BD_MIN;
    if (bd > BD_MAX) bd = BD_MAX;
    return bd;
  endfunction

  function automatic logic [RECIP_W-1:0] exact_recip(logic [DEPTH_W-1:0] depth);
    logic [63:0] alpha;
    logic [63:0] r;
    alpha = (depth < OPACITY_SCALE - 1) ? 64'(depth) : 64'(OPACITY_SCALE - 1);
    r = (64'd1 << 32) / (64'(OPACITY_SCALE) - alpha);
    // 2^32 does not fit; all ones plus the +1 correction gives the same quotient
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] blend_pixel(pix_item_t px, logic [BD_W-1:0] bd_reg);
    logic [4:0]  bd;
    logic [31:0] src, col, dep, alpha, den, n, mag, q, nq, v, pmax;
    logic [63:0] prod;
    bd  = eff_depth(bd_reg);
    col = {{(32 - COLOR_W){px.color[COLOR_W-1]}}, px.color};
    dep = 32'(px.depth);
    src = 32'(px.sample) << (20 - bd);
    if (px.command == CMD_ADD) begin
      n   = src * (OPACITY_SCALE - dep) + col * dep + OPACITY_SCALE / 2;
      mag = n[31] ? -n : n;
      q   = mag / OPACITY_SCALE;
    end else begin
      alpha = (dep < OPACITY_SCALE - 1) ? dep : OPACITY_SCALE - 1;
      den   = OPACITY_SCALE - alpha;
      n     = src * OPACITY_SCALE - col * alpha + (den >> 1);
      mag   = n[31] ? -n : n;
      prod  = 64'(mag) * 64'(px.reciprocal);
      q     = prod[63:32];
      nq    = q + 32'd1;
      if (nq * den <= mag) q = nq;
    end
    v = n[31] ? -q : q;
    if (v[31]) v = '0;
    v    = v >> (18 - bd);
    v    = (v + 32'd1) >> 2;
    pmax = (32'd1 << bd) - 32'd1;
    if (v > pmax) v = pmax;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic pix_item_t pixel_item(cmd_e c, int unsigned s, int signed col,
                                           int unsigned d, logic [RECIP_W-1:0] r);
    pix_item_t px;
    px.command    = c;
    px.sample     = SAMPLE_W'(s);
    px.color      = COLOR_W'(col);
    px.depth      = DEPTH_W'(d);
    px.reciprocal = r;
    return px;
  endfunction

  // Mostly in-range samples and opacities with a matching reciprocal;
  // the rest out-of-range values and bad reciprocals.
  function automatic pix_item_t random_pixel(logic [BD_W-1:0] bd_reg);
    pix_item_t   px;
    logic [4:0]  bd;
    int unsigned pick;
    bd = eff_depth(bd_reg);
    px.command = cmd_e'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) px.sample = SAMPLE_W'($urandom);
    else           px.sample = SAMPLE_W'($urandom_range(0, (1 << bd) - 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) px.depth = DEPTH_W'($urandom_range(OPACITY_SCALE + 1, 1023));
    else if (pick == 1) begin
      case ($urandom_range(0, 2))
        0:       px.depth = '0;
        1:       px.depth = DEPTH_W'(OPACITY_SCALE - 1);
        default: px.depth = DEPTH_W'(OPACITY_SCALE);
      endcase
    end else px.depth = DEPTH_W'($urandom_range(0, OPACITY_SCALE));
    pick = $urandom_range(0, 9);
    if (pick < 2) px.color = COLOR_W'($urandom);
    else          px.color = COLOR_W'($urandom_range(0, (1 << 20) - 1));
    pick = $urandom_range(0, 9);
    if (px.command == CMD_ADD || pick == 0) px.reciprocal = $urandom;
    else if (pick == 1) px.reciprocal = exact_recip(px.depth) + $urandom_range(1, 3);
    else if (pick == 2) px.reciprocal = exact_recip(px.depth) - $urandom_range(1, 3);
    else px.reciprocal = exact_recip(px.depth);
    return px;
  endfunction

  task automatic queue_pixel(pix_item_t px);
    pixel_todo_q.push_back(px);
    pixels_queued++;
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) queue_pixel(random_pixel(bit_depth_model));
  endtask

  // Only touch the register with the pipeline empty
  task automatic write_bit_depth(logic [BD_W-1:0] bd);
    while (pixels_sent != pixels_queued || pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_bit_depth_i <= bd;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i     <= 1'b0;
    bit_depth_model = bd;
  endtask

  // Pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pixel_expect_q.push_back('{px: on_bus, pixel: blend_pixel(on_bus, bit_depth_model)});
        pixels_sent++;
        if (on_bus.command == CMD_ERASE) erase_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pixel_todo_q.size() > 0) begin
          on_bus = pixel_todo_q.pop_front();
          in_valid_i   <= 1'b1;
          command_i    <= on_bus.command;
          sample_i     <= on_bus.sample;
          color_i      <= on_bus.color;
          depth_i      <= on_bus.depth;
          reciprocal_i <= on_bus.reciprocal;
          if ($urandom_range(0, 99) < gap_pct) send_gap = $urandom_range(1, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and sink
  always @(posedge clk_i or negedge rst_ni) begin
    pix_expect_t exp_px;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        pixels_checked++;
        if (pixel_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel transfer: expected none actual %0d",
                   $time, pixel_out_o);
        end else begin
          exp_px = pixel_expect_q.pop_front();
          if (pixel_out_o !== exp_px.pixel) begin
            errors++;
            $display("%0t: pixel_out mismatch: expected %0d actual %0d (%s smp %0d col %0d dep %0d rcp %h)",
                     $time, exp_px.pixel, pixel_out_o, exp_px.px.command.name(),
                     exp_px.px.sample, exp_px.px.color, exp_px.px.depth, exp_px.px.reciprocal);
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) sink_stall = $urandom_range(1, 5);
      end
    end
  end

  // Watchdog: no transfer on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corners at the reset bit depth (8)
    queue_pixel(pixel_item(CMD_ADD,   0,     0,         0,    '0));
    queue_pixel(pixel_item(CMD_ADD,   255,   0,         0,    '0));
    queue_pixel(pixel_item(CMD_ADD,   65535, 0,         0,    32'hFFFF_FFFF));
    queue_pixel(pixel_item(CMD_ADD,   0,     1048575,   1000, '0));
    queue_pixel(pixel_item(CMD_ADD,   255,   -1048576,  1000, '0));
    queue_pixel(pixel_item(CMD_ADD,   255,   700000,    1023, '0));
    queue_pixel(pixel_item(CMD_ADD,   128,   524288,    500,  '0));
    queue_pixel(pixel_item(CMD_ADD,   65535, 1048575,   1,    '0));
    queue_pixel(pixel_item(CMD_ERASE, 200,   300000,    0,    exact_recip(0)));
    queue_pixel(pixel_item(CMD_ERASE, 200,   300000,    999,  exact_recip(999)));
    queue_pixel(pixel_item(CMD_ERASE, 200,   300000,    1000, exact_recip(1000)));
    queue_pixel(pixel_item(CMD_ERASE, 200,   300000,    1023, exact_recip(1023)));
    queue_pixel(pixel_item(CMD_ERASE, 255,   1048575,   500,  exact_recip(500)));
    queue_pixel(pixel_item(CMD_ERASE, 255,   -1048576,  999,  exact_recip(999)));
    queue_pixel(pixel_item(CMD_ERASE, 0,     1048575,   999,  exact_recip(999)));
    queue_pixel(pixel_item(CMD_ERASE, 180,   100000,    300,  '0));
    queue_pixel(pixel_item(CMD_ERASE, 180,   100000,    300,  32'hFFFF_FFFF));
    queue_pixel(pixel_item(CMD_ERASE, 180,   100000,    300,  exact_recip(300) - 1));
    queue_pixel(pixel_item(CMD_ERASE, 180,   100000,    300,  exact_recip(300) + 1));
    queue_pixel(pixel_item(CMD_ERASE, 65535, -1048576,  1000, exact_recip(1000)));
    queue_random(RAND_PER_SETTING);

    for (int i = 0; i < PLAN_LEN; i++) begin
      write_bit_depth(BD_PLAN[i]);
      if (i == PLAN_LEN - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 3) * 15;
        stall_pct = $urandom_range(0, 3) * 15;
      end
      queue_random(RAND_PER_SETTING);
    end

    while (pixels_sent != pixels_queued || pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d pixels (%0d erase) over %0d bit-depth settings incl. odd/out-of-range",
             pixels_checked, erase_sent, PLAN_LEN + 1);
    $display("Mismatches: %0d", errors);
    if (errors == 0 && pixel_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
